/* rtl/rbsi_pkg.sv */
// shared constants and types for the ray/box slab test
`timescale 1ns / 1ps
package rbsi_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned NumW   = CoordW + 1;
  localparam int unsigned DivW   = NumW + 16;
  localparam int unsigned NumAx  = 3;
  localparam int unsigned FracBits = 16;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
  } ray_box_t;

  localparam coord_t TMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam coord_t TMin = {1'b1, {(CoordW-1){1'b0}}};
endpackage

/* rtl/rbsi_if.sv */
// valid/ready channel interfaces for requests and results
`timescale 1ns / 1ps
interface rbsi_in_if;
  logic              valid;
  logic              ready;
  rbsi_pkg::ray_box_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rbsi_out_if;
  logic                 valid;
  logic                 ready;
  rbsi_pkg::coord_t     distance;
  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

/* rtl/rbsi_div.sv */
// pipelined signed divider, one quotient bit per stage, with saturation
`timescale 1ns / 1ps
module rbsi_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic signed [rbsi_pkg::NumW-1:0]   num,
  input  logic signed [rbsi_pkg::CoordW-1:0] den,
  output rbsi_pkg::coord_t              quo
);
  import rbsi_pkg::*;

  localparam int unsigned St = DivW;

  // per stage: partial remainder, quotient bits, divisor magnitude, signs
  logic [DivW-1:0]   rem_r [St+1];
  logic [DivW-1:0]   q_r   [St+1];
  logic [CoordW-1:0] d_r   [St+1];
  logic              neg_r [St+1];
  logic              zero_r[St+1];
  logic              nneg_r[St+1];

  logic [NumW-1:0]   nmag;
  logic [CoordW-1:0] dmag;

  assign nmag = num[NumW-1] ? NumW'(-num) : NumW'(num);
  assign dmag = den[CoordW-1] ? CoordW'(-den) : CoordW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      q_r[0]    <= {nmag, {FracBits{1'b0}}};
      d_r[0]    <= dmag;
      neg_r[0]  <= num[NumW-1] ^ den[CoordW-1];
      zero_r[0] <= (den == '0);
      nneg_r[0] <= num[NumW-1];
    end
  end

  for (genvar s = 0; s < St; s++) begin : g_st
    logic [DivW:0] sh;
    logic [DivW:0] df;
    assign sh = {rem_r[s], q_r[s][DivW-1]};
    assign df = sh - {{(DivW+1-CoordW){1'b0}}, d_r[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= df[DivW] ? sh[DivW-1:0] : df[DivW-1:0];
        q_r[s+1]    <= {q_r[s][DivW-2:0], ~df[DivW]};
        d_r[s+1]    <= d_r[s];
        neg_r[s+1]  <= neg_r[s];
        zero_r[s+1] <= zero_r[s];
        nneg_r[s+1] <= nneg_r[s];
      end
    end
  end

  // saturate magnitude and apply sign
  logic big;
  logic [DivW:0] sq;
  always_comb begin
    sq  = neg_r[St] ? -{1'b0, q_r[St]} : {1'b0, q_r[St]};
    big = neg_r[St] ? (q_r[St] > DivW'(33'h080000000))
                    : (q_r[St] > DivW'(33'h07FFFFFFF));
    if (zero_r[St])      quo = nneg_r[St] ? TMin : TMax;
    else if (big)        quo = neg_r[St] ? TMin : TMax;
    else                 quo = coord_t'(sq[CoordW-1:0]);
  end

  logic unused_rst;
  assign unused_rst = rst_n;
endmodule

/* rtl/ray_box_slab_intersect.sv */
// top level: ray against axis-aligned box slab test, one request per cycle unless the output stalls
// request to result: operand stage, divider (input stage and array), order stage, result stage
// throughput: one request per clock unless the output stalls; the 49-stage restoring divider array sets depth
// stalls freeze the whole pipeline; a valid result waits in the output register
// reset clears only the valid bits; data registers carry no reset
`timescale 1ns / 1ps
module ray_box_slab_intersect (
  input logic clk,
  input logic rst_n,
  rbsi_in_if.sink    in_ch,
  rbsi_out_if.source out_ch
);
  import rbsi_pkg::*;

  // operand stage, divider input stage, divider array, order stage, result stage
  localparam int unsigned Lat = DivW + 4;

  logic en;
  logic [Lat-1:0] vld_r;
  assign en = ~vld_r[Lat-1] | out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[Lat-2:0], in_ch.valid};
  end

  // stage 0: numerators
  logic signed [NumW-1:0] nl_r [NumAx];
  logic signed [NumW-1:0] nh_r [NumAx];
  coord_t                 dr_r [NumAx];
  coord_t org [NumAx];
  coord_t dir [NumAx];
  coord_t lo  [NumAx];
  coord_t hi  [NumAx];
  assign org = '{in_ch.data.origin_x, in_ch.data.origin_y, in_ch.data.origin_z};
  assign dir = '{in_ch.data.dir_x, in_ch.data.dir_y, in_ch.data.dir_z};
  assign lo  = '{in_ch.data.lo_x, in_ch.data.lo_y, in_ch.data.lo_z};
  assign hi  = '{in_ch.data.hi_x, in_ch.data.hi_y, in_ch.data.hi_z};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NumAx; a++) begin
        nl_r[a] <= NumW'(lo[a]) - NumW'(org[a]);
        nh_r[a] <= NumW'(hi[a]) - NumW'(org[a]);
        dr_r[a] <= dir[a];
      end
    end
  end

  coord_t ta [NumAx];
  coord_t tb [NumAx];
  for (genvar a = 0; a < NumAx; a++) begin : g_ax
    rbsi_div u_dl (.clk, .rst_n, .en, .num(nl_r[a]), .den(dr_r[a]), .quo(ta[a]));
    rbsi_div u_dh (.clk, .rst_n, .en, .num(nh_r[a]), .den(dr_r[a]), .quo(tb[a]));
  end

  // order each pair
  coord_t n_r [NumAx];
  coord_t f_r [NumAx];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NumAx; a++) begin
        n_r[a] <= (ta[a] > tb[a]) ? tb[a] : ta[a];
        f_r[a] <= (ta[a] > tb[a]) ? ta[a] : tb[a];
      end
    end
  end

  // intersect intervals and pick the distance
  coord_t dist_nxt;
  coord_t dist_r;
  always_comb begin
    coord_t tn;
    coord_t tf;
    logic   miss;
    tn = n_r[0];
    tf = f_r[0];
    miss = 1'b0;
    for (int a = 1; a < NumAx; a++) begin
      if (tn > f_r[a] || n_r[a] > tf) miss = 1'b1;
      if (n_r[a] > tn) tn = n_r[a];
      if (f_r[a] < tf) tf = f_r[a];
    end
    dist_nxt = miss ? '0 : ((tn > 0) ? tn : tf);
  end

  always_ff @(posedge clk) begin
    if (en) dist_r <= dist_nxt;
  end

  assign out_ch.valid    = vld_r[Lat-1];
  assign out_ch.distance = dist_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(dist_r) && out_ch.valid)
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("pipeline stalled without a waiting result");
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted request lost");
endmodule

/* test/rbsi_box_checker.sv */
// checker: predicts slab test distances from observed requests and compares results
`timescale 1ns / 1ps
module rbsi_box_checker (
  input  logic       clk,
  input  logic       rst_n,
  rbsi_in_if.sink    in_mon,
  rbsi_out_if.sink   out_mon,
  output int         fail_count,
  output int         pending_dists
);
  import rbsi_pkg::*;

  coord_t dist_q[$];

  function automatic longint slab_t(longint bound, longint org, longint dirv);
    longint num;
    longint q;
    num = bound - org;
    if (dirv == 0) return (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
    q = (num * 65536) / dirv;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic coord_t hit_distance(ray_box_t r);
    longint org[3], dv[3], lo[3], hi[3];
    longint a, b, tn, tf, an, af;
    org = '{longint'(r.origin_x), longint'(r.origin_y), longint'(r.origin_z)};
    dv  = '{longint'(r.dir_x), longint'(r.dir_y), longint'(r.dir_z)};
    lo  = '{longint'(r.lo_x), longint'(r.lo_y), longint'(r.lo_z)};
    hi  = '{longint'(r.hi_x), longint'(r.hi_y), longint'(r.hi_z)};
    for (int ax = 0; ax < 3; ax++) begin
      a = slab_t(lo[ax], org[ax], dv[ax]);
      b = slab_t(hi[ax], org[ax], dv[ax]);
      an = (a > b) ? b : a;
      af = (a > b) ? a : b;
      if (ax == 0) begin
        tn = an;
        tf = af;
      end else begin
        if (tn > af || an > tf) return '0;
        if (an > tn) tn = an;
        if (af < tf) tf = af;
      end
    end
    return coord_t'((tn > 0) ? tn : tf);
  endfunction

  task automatic report(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_dists = 0;
  end

  always @(posedge clk) begin
    coord_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) dist_q.push_back(hit_distance(in_mon.data));
      if (out_mon.valid && out_mon.ready) begin
        if (dist_q.size() == 0) begin
          report($sformatf("unexpected distance %0d", out_mon.distance));
        end else begin
          want = dist_q.pop_front();
          if (out_mon.distance !== want)
            report($sformatf("distance got %0d want %0d", out_mon.distance, want));
        end
      end
    end
    pending_dists = dist_q.size();
  end
endmodule

/* test/testbench.sv */
// top: drives ray/box requests through the slab test under varying stalls
`timescale 1ns / 1ps
module testbench;
  import rbsi_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_dists;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   n_sent;

  rbsi_in_if  in_ch ();
  rbsi_out_if out_ch ();

  ray_box_slab_intersect u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  rbsi_box_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_dists(pending_dists)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic coord_t rnd_coord();
    case ($urandom_range(5))
      0: return TMax;
      1: return TMin;
      2: return coord_t'($urandom_range(4));
      3: return coord_t'($signed($urandom_range(65536 * 64)) - 65536 * 32);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // mostly boxes around the ray path so hits are common
  function automatic ray_box_t rnd_ray_box();
    ray_box_t r;
    coord_t   c, h;
    r = '{default: '0};
    if ($urandom_range(3) == 0) begin
      r = ray_box_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(1)) r.dir_y = rnd_coord();
      return r;
    end
    for (int ax = 0; ax < 3; ax++) begin
      c = coord_t'($signed($urandom_range(65536 * 40)) - 65536 * 20);
      h = coord_t'($urandom_range(65536 * 8));
      case (ax)
        0: begin
          r.origin_x = c + coord_t'($signed($urandom_range(65536 * 8)) - 65536 * 4);
          r.dir_x = ($urandom_range(9) == 0) ? rnd_coord()
                    : coord_t'($signed($urandom_range(65536 * 4)) - 65536 * 2);
          r.lo_x = c - h;
          r.hi_x = c + h;
        end
        1: begin
          r.origin_y = c + coord_t'($signed($urandom_range(65536 * 8)) - 65536 * 4);
          r.dir_y = ($urandom_range(9) == 0) ? rnd_coord()
                    : coord_t'($signed($urandom_range(65536 * 4)) - 65536 * 2);
          r.lo_y = c - h;
          r.hi_y = c + h;
        end
        default: begin
          r.origin_z = c + coord_t'($signed($urandom_range(65536 * 8)) - 65536 * 4);
          r.dir_z = ($urandom_range(9) == 0) ? rnd_coord()
                    : coord_t'($signed($urandom_range(65536 * 4)) - 65536 * 2);
          r.lo_z = c - h;
          r.hi_z = c + h;
        end
      endcase
    end
    if ($urandom_range(7) == 0) begin
      r.lo_x = r.hi_x + 1;
    end
    return r;
  endfunction

  task automatic send_request(ray_box_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
  endtask

  function automatic ray_box_t unit_ray(coord_t ox, coord_t dx, coord_t lo, coord_t hi);
    ray_box_t r;
    r = '{default: '0};
    r.origin_x = ox;
    r.dir_x = dx;
    r.dir_y = 32'sh10000;
    r.dir_z = 32'sh10000;
    r.lo_x = lo;
    r.hi_x = hi;
    r.lo_y = -32'sh100000;
    r.hi_y = 32'sh100000;
    r.lo_z = -32'sh100000;
    r.hi_z = 32'sh100000;
    return r;
  endfunction

  task automatic directed_part();
    ray_box_t r;
    send_request('{default: '0});
    send_request('{default: TMax});
    send_request('{default: TMin});
    send_request(unit_ray(32'sh0, 32'sh10000, 32'sh20000, 32'sh50000));
    send_request(unit_ray(32'sh0, -32'sh10000, 32'sh20000, 32'sh50000));
    send_request(unit_ray(32'sh0, 32'sh0, 32'sh20000, 32'sh50000));
    send_request(unit_ray(32'sh30000, 32'sh0, 32'sh20000, 32'sh50000));
    send_request(unit_ray(32'sh0, 32'sh10000, 32'sh50000, 32'sh20000));
    send_request(unit_ray(32'sh0, 32'sh1, TMin, TMax));
    send_request(unit_ray(TMin, TMax, TMax, TMin));
    send_request(unit_ray(32'sh30000, 32'sh10000, 32'sh20000, 32'sh50000));
    send_request(unit_ray(32'sh60000, 32'sh10000, 32'sh20000, 32'sh50000));
    // touching intervals: x slab ends at 2, y slab starts at 2
    r = unit_ray(32'sh0, 32'sh10000, 32'sh10000, 32'sh20000);
    r.dir_y = 32'sh10000;
    r.lo_y = 32'sh20000;
    r.hi_y = 32'sh30000;
    send_request(r);
    r.lo_y = 32'sh20001;
    send_request(r);
    // gap on z only
    r = unit_ray(32'sh0, 32'sh10000, 32'sh10000, 32'sh20000);
    r.lo_z = 32'sh30000;
    r.hi_z = 32'sh40000;
    send_request(r);
    r.lo_z = -32'sh10000;
    r.hi_z = 32'sh18000;
    send_request(r);
    r = '{default: '0};
    r.dir_x = TMin;
    r.dir_y = TMax;
    r.dir_z = -32'sh1;
    r.hi_x = TMax;
    r.lo_y = TMin;
    r.hi_z = 32'sh1;
    send_request(r);
  endtask

  initial begin
    int phase_items[4];
    int idle_set[4];
    int stall_set[4];
    idle_set = '{0, 67, 0, 35};
    stall_set = '{0, 0, 67, 35};
    phase_items = '{460, 410, 410, 410};
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_part();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      for (int i = 0; i < phase_items[ph]; i++) send_request(rnd_ray_box());
      // stretch without sender idles between phases; the receiver keeps its stall mix
      send_idle_pct = 0;
      for (int i = 0; i < 40; i++) send_request(rnd_ray_box());
    end
    in_ch.valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_dists != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d ray/box requests (edge values, touching, zero and inverted slabs)",
             n_sent);
    $display("under idle/stall mixes 0/0, 67/0, 0/67, 35/35");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/rbsi_pkg.sv
rtl/rbsi_if.sv
rtl/rbsi_div.sv
rtl/ray_box_slab_intersect.sv
test/rbsi_box_checker.sv
test/testbench.sv
